// ===== src/sorted_priority_queue_assert.svh =====
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks an implication from a trigger to a condition on the same edge.
`define SPQ_ASSERT_IMPLY(label, trig, cond, msg) \
    `SPQ_ASSERT(label, (trig) |-> (cond), msg)

`endif

// ===== src/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int PRIO_W       = 8;
    localparam int PAY_FIELD_W  = 32;
    localparam int OCC_W        = 5;
    localparam int STATUS_W     = 3;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_TOP      = 2'd1,
        OP_AT_LEAST = 2'd2,
        OP_EXACT    = 2'd3
    } t_opcode;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_LEFT,
        CELL_RIGHT
    } t_cell_op;

    typedef struct packed {
        logic [PRIO_W-1:0]       prio;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    typedef struct packed {
        t_opcode                opcode;
        logic [PRIO_W-1:0]      priority_req;
        logic [PAY_FIELD_W-1:0] payload;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [PRIO_W-1:0]      priority_res;
        logic [PAY_FIELD_W-1:0] payload_res;
        logic                   last;
        logic [OCC_W-1:0]       occupancy;
    } t_out_item;

    // Length of a mask whose set bits form one run starting at bit zero.
    function automatic logic [CNT_W-1:0] therm_len(input logic [DEPTH-1:0] m);
        logic [DEPTH:0]   ext;
        logic [CNT_W-1:0] len;
        ext = {1'b0, m};
        len = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (ext[i] && !ext[i + 1]) begin
                len = len | CNT_W'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
// Channel  Direction  Signals                              Moves
// in       input      i_in_valid, o_in_ready, i_in_data   one operation request
// out      output     o_out_valid, i_out_ready, o_out_data one result
//
// Insert, full, empty and no-match requests go from S_IDLE, which takes
// the transfer, to S_SCAN, which compares all cells in parallel.
// An extraction that removes n entries, extract top included, goes on to
// S_EMIT for n results; cells shift down a slot per delivered result.
// Reset is synchronous and empties the queue; entry storage is not cleared.
// A stalled output holds the current result and the sequence waits for it.
`default_nettype none

module sorted_priority_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire spq_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output spq_pkg::t_out_item o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                         r_state, n_state;
    spq_pkg::t_in_item              r_req, n_req;
    logic [spq_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [spq_pkg::CNT_W-1:0]      r_left, n_left;
    logic [spq_pkg::DEPTH-1:0]      r_shift, n_shift;
    logic                           r_out_valid, n_out_valid;
    spq_pkg::t_out_item             r_out, n_out;

    spq_pkg::t_cell_op              w_op [spq_pkg::DEPTH];
    spq_pkg::t_entry                w_cell [spq_pkg::DEPTH];
    spq_pkg::t_entry                w_left [spq_pkg::DEPTH];
    spq_pkg::t_entry                w_right [spq_pkg::DEPTH];
    spq_pkg::t_entry                w_new;
    logic [spq_pkg::DEPTH-1:0]      w_cell_lt, w_cell_eq;
    logic [spq_pkg::DEPTH-1:0]      w_valid, w_lt, w_le, w_sel;
    logic [spq_pkg::CNT_W-1:0]      w_lo, w_hi, w_num;
    logic [spq_pkg::PRIO_W-1:0]     w_sel_prio;
    logic [spq_pkg::PAYLOAD_BITS-1:0] w_sel_payload;
    logic                           w_out_free;

    assign w_new.prio    = r_req.priority_req;
    assign w_new.payload = r_req.payload[spq_pkg::PAYLOAD_BITS-1:0];

    for (genvar g = 0; g < spq_pkg::DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = w_new;
        end else begin : g_mid
            assign w_left[g] = w_cell[g - 1];
        end
        if (g == spq_pkg::DEPTH - 1) begin : g_end
            assign w_right[g] = w_cell[g];
        end else begin : g_body
            assign w_right[g] = w_cell[g + 1];
        end

        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op[g]),
            .i_key   (r_req.priority_req),
            .i_new   (w_new),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_entry (w_cell[g]),
            .o_lt    (w_cell_lt[g]),
            .o_eq    (w_cell_eq[g])
        );
    end

    always_comb begin
        for (int i = 0; i < spq_pkg::DEPTH; i++) begin
            w_valid[i] = spq_pkg::CNT_W'(i) < r_cnt;
        end
        w_lt = w_valid & w_cell_lt;
        w_le = w_valid & (w_cell_lt | w_cell_eq);
        w_lo = spq_pkg::therm_len(w_lt);
        w_hi = spq_pkg::therm_len(w_le);
    end

    always_comb begin
        w_sel         = r_shift & ~(r_shift << 1);
        w_sel_prio    = '0;
        w_sel_payload = '0;
        for (int i = 0; i < spq_pkg::DEPTH; i++) begin
            if (w_sel[i]) begin
                w_sel_prio    = w_sel_prio | w_cell[i].prio;
                w_sel_payload = w_sel_payload | w_cell[i].payload;
            end
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_shift     = r_shift;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_num       = '0;
        for (int i = 0; i < spq_pkg::DEPTH; i++) begin
            w_op[i] = spq_pkg::CELL_HOLD;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_out_free) begin
                    n_state              = S_IDLE;
                    n_out_valid          = 1'b1;
                    n_out.priority_res   = '0;
                    n_out.payload_res    = '0;
                    n_out.last           = 1'b1;
                    n_out.occupancy      = spq_pkg::OCC_W'(r_cnt);
                    if (r_req.opcode == spq_pkg::OP_INSERT) begin
                        if (r_cnt == spq_pkg::CNT_W'(spq_pkg::DEPTH)) begin
                            n_out.status = spq_pkg::ST_FULL;
                        end else begin
                            for (int i = 0; i < spq_pkg::DEPTH; i++) begin
                                if (w_lt[i]) begin
                                    w_op[i] = spq_pkg::CELL_HOLD;
                                end else if (i == 0) begin
                                    w_op[i] = spq_pkg::CELL_LOAD;
                                end else if (w_lt[(i == 0) ? 0 : i - 1]) begin
                                    w_op[i] = spq_pkg::CELL_LOAD;
                                end else begin
                                    w_op[i] = spq_pkg::CELL_LEFT;
                                end
                            end
                            n_cnt           = r_cnt + spq_pkg::CNT_W'(1);
                            n_out.status    = spq_pkg::ST_INSERTED;
                            n_out.occupancy = spq_pkg::OCC_W'(n_cnt);
                        end
                    end else if (r_cnt == '0) begin
                        n_out.status = spq_pkg::ST_EMPTY;
                    end else begin
                        case (r_req.opcode)
                            spq_pkg::OP_TOP: begin
                                w_num = spq_pkg::CNT_W'(1);
                                for (int i = 0; i < spq_pkg::DEPTH; i++) begin
                                    n_shift[i] = spq_pkg::CNT_W'(i) + spq_pkg::CNT_W'(1)
                                        >= r_cnt;
                                end
                            end
                            spq_pkg::OP_AT_LEAST: begin
                                w_num   = r_cnt - w_lo;
                                n_shift = ~w_lt;
                            end
                            default: begin
                                w_num   = w_hi - w_lo;
                                n_shift = ~w_lt;
                            end
                        endcase
                        if (w_num == '0) begin
                            n_out.status = spq_pkg::ST_NONE;
                        end else begin
                            n_out_valid = 1'b0;
                            n_left      = w_num;
                            n_cnt       = r_cnt - w_num;
                            n_state     = S_EMIT;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = spq_pkg::ST_DELIVERED;
                    n_out.priority_res = w_sel_prio;
                    n_out.payload_res  = spq_pkg::PAY_FIELD_W'(w_sel_payload);
                    n_out.last         = r_left == spq_pkg::CNT_W'(1);
                    n_out.occupancy    = spq_pkg::OCC_W'(r_cnt);
                    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
                        if (r_shift[i]) begin
                            w_op[i] = spq_pkg::CELL_RIGHT;
                        end
                    end
                    n_left = r_left - spq_pkg::CNT_W'(1);
                    if (r_left == spq_pkg::CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_shift <= n_shift;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== src/spq_cell.sv =====
`default_nettype none

module spq_cell (
    input  wire logic                      i_clk,
    input  wire spq_pkg::t_cell_op         i_op,
    input  wire logic [spq_pkg::PRIO_W-1:0] i_key,
    input  wire spq_pkg::t_entry           i_new,
    input  wire spq_pkg::t_entry           i_left,
    input  wire spq_pkg::t_entry           i_right,
    output spq_pkg::t_entry                o_entry,
    output logic                           o_lt,
    output logic                           o_eq
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    always_comb begin
        unique case (i_op)
            spq_pkg::CELL_LOAD:  n_entry = i_new;
            spq_pkg::CELL_LEFT:  n_entry = i_left;
            spq_pkg::CELL_RIGHT: n_entry = i_right;
            default:             n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_lt    = r_entry.prio < i_key;
    assign o_eq    = r_entry.prio == i_key;

endmodule

`default_nettype wire

// ===== src/spq_checker.sv =====
`default_nettype none

`include "sorted_priority_queue_assert.svh"

module spq_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_ready,
    input wire spq_pkg::t_in_item  i_in_data,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire spq_pkg::t_out_item o_out_data
);

    `SPQ_ASSERT(a_in_hold, i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data), "waiting request changed")

    `SPQ_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "stalled result changed")

    `SPQ_ASSERT_IMPLY(a_status_only, o_out_valid && o_out_data.status != spq_pkg::ST_DELIVERED, o_out_data.last && o_out_data.priority_res == '0 && o_out_data.payload_res == '0, "status result malformed")

    `SPQ_ASSERT_IMPLY(a_full_occ, o_out_valid && o_out_data.status == spq_pkg::ST_FULL, o_out_data.occupancy == spq_pkg::OCC_W'(spq_pkg::DEPTH), "full reported below capacity")

    `SPQ_ASSERT_IMPLY(a_empty_occ, o_out_valid && o_out_data.status == spq_pkg::ST_EMPTY, o_out_data.occupancy == '0, "empty reported with entries held")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire

// ===== verif/sorted_priority_queue_checker.sv =====
module sorted_priority_queue_checker
    import spq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_ready,
    input  t_in_item  i_in_data,
    input  wire logic i_out_valid,
    input  wire logic i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_requests,
    output int        o_results,
    output int        o_full_seen,
    output int        o_empty_seen,
    output int        o_none_seen
);

    localparam int REPORT_LIMIT = 40;
    localparam logic [PAY_FIELD_W-1:0] PAY_MASK =
        {PAY_FIELD_W{1'b1}} >> (PAY_FIELD_W - PAYLOAD_BITS);

    logic [PRIO_W-1:0]      held_prio    [DEPTH];
    logic [PAY_FIELD_W-1:0] held_payload [DEPTH];
    int                     held_count = 0;
    t_out_item              queued_outcomes [$];

    int fails      = 0;
    int requests   = 0;
    int results    = 0;
    int full_seen  = 0;
    int empty_seen = 0;
    int none_seen  = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_requests   = 0;
        o_results    = 0;
        o_full_seen  = 0;
        o_empty_seen = 0;
        o_none_seen  = 0;
    end

    task automatic queue_outcome(input logic [STATUS_W-1:0] status,
                                 input logic [PRIO_W-1:0] prio,
                                 input logic [PAY_FIELD_W-1:0] pay,
                                 input logic last_flag,
                                 input int occupancy);
        t_out_item outcome;
        outcome.status       = status;
        outcome.priority_res = prio;
        outcome.payload_res  = pay;
        outcome.last         = last_flag;
        outcome.occupancy    = OCC_W'(occupancy);
        queued_outcomes.push_back(outcome);
    endtask

    // Delivers slots lo up to hi-1 in storage order and closes the gap.
    task automatic remove_span(input int lo, input int hi);
        int span;
        span = hi - lo;
        for (int i = lo; i < hi; i++) begin
            queue_outcome(ST_DELIVERED, held_prio[i], held_payload[i], i == hi - 1,
                          held_count - span);
        end
        for (int i = lo; i + span < held_count; i++) begin
            held_prio[i]    = held_prio[i + span];
            held_payload[i] = held_payload[i + span];
        end
        held_count -= span;
    endtask

    task automatic apply_request(input t_in_item req);
        int pos;
        int stop;
        requests++;
        if (req.opcode == OP_INSERT) begin
            if (held_count >= DEPTH) begin
                queue_outcome(ST_FULL, '0, '0, 1'b1, held_count);
                full_seen++;
            end else begin
                pos = 0;
                while (pos < held_count && held_prio[pos] < req.priority_req) pos++;
                for (int i = held_count; i > pos; i--) begin
                    held_prio[i]    = held_prio[i - 1];
                    held_payload[i] = held_payload[i - 1];
                end
                held_prio[pos]    = req.priority_req;
                held_payload[pos] = req.payload & PAY_MASK;
                held_count++;
                queue_outcome(ST_INSERTED, '0, '0, 1'b1, held_count);
            end
        end else if (held_count == 0) begin
            queue_outcome(ST_EMPTY, '0, '0, 1'b1, 0);
            empty_seen++;
        end else if (req.opcode == OP_TOP) begin
            remove_span(held_count - 1, held_count);
        end else begin
            pos = 0;
            while (pos < held_count && held_prio[pos] < req.priority_req) pos++;
            stop = pos;
            if (req.opcode == OP_AT_LEAST) begin
                stop = held_count;
            end else begin
                while (stop < held_count && held_prio[stop] == req.priority_req) stop++;
            end
            if (stop == pos) begin
                queue_outcome(ST_NONE, '0, '0, 1'b1, held_count);
                none_seen++;
            end else begin
                remove_span(pos, stop);
            end
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
                $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            end else if (fails == REPORT_LIMIT + 1) begin
                $display("%0t: further mismatch reports suppressed", $time);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            held_count = 0;
            queued_outcomes.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                apply_request(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                results++;
                if (queued_outcomes.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT) begin
                        $display("%0t: result transfer with nothing expected, actual %p",
                                 $time, i_out_data);
                    end
                end else begin
                    want = queued_outcomes.pop_front();
                    check_field("status", 32'(want.status), 32'(i_out_data.status));
                    check_field("priority_res", 32'(want.priority_res),
                                32'(i_out_data.priority_res));
                    check_field("payload_res", 32'(want.payload_res),
                                32'(i_out_data.payload_res));
                    check_field("last", 32'(want.last), 32'(i_out_data.last));
                    check_field("occupancy", 32'(want.occupancy),
                                32'(i_out_data.occupancy));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= queued_outcomes.size();
        o_requests   <= requests;
        o_results    <= results;
        o_full_seen  <= full_seen;
        o_empty_seen <= empty_seen;
        o_none_seen  <= none_seen;
    end

endmodule

// ===== verif/sorted_priority_queue_tb.sv =====
module sorted_priority_queue_tb;

    import spq_pkg::*;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    logic        out_gappy  = 1'b0;
    int unsigned stall_left = 0;
    bit          in_gappy   = 1'b0;
    bit          idle_on    = 1'b0;

    int fail_count;
    int pending;
    int requests;
    int results;
    int full_seen;
    int empty_seen;
    int none_seen;

    sorted_priority_queue u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    sorted_priority_queue_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_requests   (requests),
        .o_results    (results),
        .o_full_seen  (full_seen),
        .o_empty_seen (empty_seen),
        .o_none_seen  (none_seen)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n || !out_gappy) begin
            out_ready  <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic t_in_item request_of(input t_opcode op, input logic [7:0] prio,
                                            input logic [31:0] pay);
        t_in_item req;
        req.opcode       = op;
        req.priority_req = prio;
        req.payload      = pay;
        return req;
    endfunction

    function automatic t_in_item random_request(input int unsigned insert_pct,
                                                input int unsigned prio_max);
        t_in_item req;
        if ($urandom_range(0, 99) < insert_pct) begin
            req.opcode = OP_INSERT;
        end else begin
            req.opcode = t_opcode'($urandom_range(1, 3));
        end
        req.priority_req = 8'($urandom_range(0, prio_max));
        req.payload      = $urandom();
        return req;
    endfunction

    task automatic send_request(input t_in_item req);
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (in_gappy && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic run_random(input int count, input int unsigned insert_pct,
                              input int unsigned prio_max);
        for (int n = 0; n < count; n++) begin
            if (n % 16 == 0) begin
                in_gappy  = idle_on && $urandom_range(0, 2) != 0;
                out_gappy <= idle_on && $urandom_range(0, 2) != 0;
            end
            send_request(random_request(insert_pct, prio_max));
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(request_of(OP_TOP, 8'd0, $urandom()));
        send_request(request_of(OP_AT_LEAST, 8'd0, $urandom()));
        send_request(request_of(OP_EXACT, 8'd255, $urandom()));
        send_request(request_of(OP_INSERT, 8'd0, 32'h0000_0000));
        send_request(request_of(OP_INSERT, 8'd255, 32'hFFFF_FFFF));
        send_request(request_of(OP_INSERT, 8'd128, 32'hA5A5_5A5A));
        send_request(request_of(OP_INSERT, 8'd128, 32'h5A5A_A5A5));
        send_request(request_of(OP_INSERT, 8'd0, 32'h0000_0001));
        send_request(request_of(OP_EXACT, 8'd128, $urandom()));
        send_request(request_of(OP_EXACT, 8'd77, $urandom()));
        send_request(request_of(OP_AT_LEAST, 8'd200, $urandom()));
        send_request(request_of(OP_TOP, 8'd0, $urandom()));
        send_request(request_of(OP_AT_LEAST, 8'd0, $urandom()));
        wait_drained();

        idle_on = 1'b1;
        run_random(120, 55, 255);
        wait_drained();
        run_random(100, 75, 7);
        send_request(request_of(OP_AT_LEAST, 8'd0, $urandom()));
        wait_drained();

        idle_on = 1'b0;
        run_random(100, 50, 31);
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Covered %0d requests and %0d result transfers over all four operations.",
                 requests, results);
        $display("Full seen %0d times, empty %0d times, no match %0d times.",
                 full_seen, empty_seen, none_seen);
        if (fail_count == 0) begin
            $display("sorted_priority_queue: match");
        end else begin
            $display("sorted_priority_queue: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("sorted_priority_queue: mismatch");
        $finish;
    end

endmodule

// ===== sorted_priority_queue.f =====
+incdir+src
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
src/spq_checker.sv
verif/sorted_priority_queue_checker.sv
verif/sorted_priority_queue_tb.sv
